[hdl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, register codes and configuration structs of the meter
// sample conditioner.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 24;
    localparam int LIMIT_W    = 23;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SEQ_W      = 32;
    localparam int STAMP_W    = 32;

    // full-scale spans in q.8, 100 A and 440 V
    localparam int SPAN_W = 17;
    localparam logic [SPAN_W-1:0] CURRENT_SPAN = 17'd25600;
    localparam logic [SPAN_W-1:0] VOLTAGE_SPAN = 17'd112640;

    localparam int GAIN_FRAC  = 12;
    localparam int GAIN_ROUND = 2048;

    // divide by 5 done as multiply by 51, then divide by 255
    localparam int AVG_FOLD_BITS = 8;
    localparam int AVG_MULT      = 51;

    // wide signed sum for offset and saturation
    localparam int SUM_W = 34;

    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_OFFSET = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_GAIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_LIMIT  = 3'd5;

    localparam logic [GAIN_W-1:0]   GAIN_RESET          = 16'd4096;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET        = 24'd0;
    localparam logic [LIMIT_W-1:0]  CURRENT_LIMIT_RESET = 23'd25600;
    localparam logic [LIMIT_W-1:0]  VOLTAGE_LIMIT_RESET = 23'd112640;

    typedef struct packed {
        logic [GAIN_W-1:0]   current_gain;
        logic [OFFSET_W-1:0] current_offset;
        logic [GAIN_W-1:0]   voltage_gain;
        logic [OFFSET_W-1:0] voltage_offset;
    } front_cfg_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] current_limit;
        logic [LIMIT_W-1:0] voltage_limit;
    } back_cfg_t;

endpackage

[hdl/msc_in_if.sv]
// ----------------------------------------------------------------------------
// msc_in_if
// Sample pair channel: two converter samples and a millisecond stamp.
// ----------------------------------------------------------------------------
interface msc_in_if #(
    parameter int ADC_BITS = 12
) ();
    logic                         valid;
    logic                         ready;
    logic [ADC_BITS-1:0]          raw_current;
    logic [ADC_BITS-1:0]          raw_voltage;
    logic [msc_pkg::STAMP_W-1:0]  time_ms;

    modport source (output valid, raw_current, raw_voltage, time_ms, input ready);
    modport sink   (input valid, raw_current, raw_voltage, time_ms, output ready);
endinterface

[hdl/msc_out_if.sv]
// ----------------------------------------------------------------------------
// msc_out_if
// Result channel: averaged values, anomaly flag, sequence number and stamp.
// ----------------------------------------------------------------------------
interface msc_out_if #(
    parameter int VALUE_WIDTH = 24
) ();
    logic                                valid;
    logic                                ready;
    logic signed [VALUE_WIDTH-1:0]       avg_current;
    logic signed [VALUE_WIDTH-1:0]       avg_voltage;
    logic                                anomaly;
    logic [msc_pkg::SEQ_W-1:0]           sequence_res;
    logic [msc_pkg::STAMP_W-1:0]         stamp_ms;

    modport source (output valid, avg_current, avg_voltage, anomaly, sequence_res,
                    stamp_ms, input ready);
    modport sink   (input valid, avg_current, avg_voltage, anomaly, sequence_res,
                    stamp_ms, output ready);
endinterface

[hdl/msc_cfg_if.sv]
// ----------------------------------------------------------------------------
// msc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface msc_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [msc_pkg::CFG_ADDR_W-1:0]   addr;
    logic [msc_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

[hdl/msc_fold_div.sv]
// ----------------------------------------------------------------------------
// msc_fold_div
// Iterative divider by 2^FOLD_BITS - 1. Each cycle folds the high part of
// the remainder onto the low part and adds it to the quotient.
// ----------------------------------------------------------------------------
module msc_fold_div #(
    parameter int FOLD_BITS = 8,
    parameter int DIV_W     = 32,
    parameter int QUO_W     = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    localparam int HIGH_W = DIV_W - FOLD_BITS;
    localparam logic [FOLD_BITS-1:0] DIVISOR = '1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [HIGH_W-1:0] high_part;
    logic [FOLD_BITS-1:0] low_part;

    assign high_part = rem_reg[DIV_W-1:FOLD_BITS];
    assign low_part  = rem_reg[FOLD_BITS-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (high_part != '0)
            begin
                quo_next = quo_reg + QUO_W'(high_part);
                rem_next = DIV_W'(high_part) + DIV_W'(low_part);
            end
            else
            begin
                // remainder below 2^n, one step short only when it equals the divisor
                quo_next  = quo_reg + QUO_W'(low_part == DIVISOR);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/msc_queue.sv]
// ----------------------------------------------------------------------------
// msc_queue
// Short first-in first-out queue between the front and back sections.
// ----------------------------------------------------------------------------
module msc_queue #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [WIDTH-1:0]  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [WIDTH-1:0]  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/msc_front.sv]
// ----------------------------------------------------------------------------
// msc_front
// Accepts a sample pair and conditions both channels: full-scale scaling,
// gain, offset and saturation, one channel after the other on one
// multiplier and one folding divider.
// ----------------------------------------------------------------------------
module msc_front #(
    parameter int ADC_BITS    = 12,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    msc_in_if.sink                                   in_ch,
    input  msc_pkg::front_cfg_t                      cfg,
    output logic                                     push_valid,
    input  logic                                     push_ready,
    output logic [2*VALUE_WIDTH+msc_pkg::STAMP_W-1:0] push_data
);
    import msc_pkg::*;

    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
    localparam int HALF_FS    = FULL_SCALE / 2;
    localparam int PROD_W     = 2 * SPAN_W;
    localparam int DIV_W      = ADC_BITS + SPAN_W;
    localparam int GAINED_W   = PROD_W - GAIN_FRAC;
    localparam longint VAL_MAX_I = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(VAL_MAX_I);
    localparam logic signed [SUM_W-1:0] VAL_MIN = SUM_W'(-VAL_MAX_I - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCALE  = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_GAIN   = 3'd4;
    localparam logic [2:0] ST_OFFSET = 3'd5;
    localparam logic [2:0] ST_PUSH   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic                          chan_reg, chan_next;
    logic [ADC_BITS-1:0]           raw_cur_reg, raw_cur_next;
    logic [ADC_BITS-1:0]           raw_volt_reg, raw_volt_next;
    logic [STAMP_W-1:0]            stamp_reg, stamp_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [VALUE_WIDTH-1:0]        x_cur_reg, x_cur_next;
    logic [VALUE_WIDTH-1:0]        x_volt_reg, x_volt_next;

    logic                          div_start;
    logic [DIV_W-1:0]              div_dividend;
    logic                          div_done;
    logic [SPAN_W-1:0]             div_quotient;

    logic [ADC_BITS-1:0]           raw_sel;
    logic [SPAN_W-1:0]             span_sel;
    logic [GAIN_W-1:0]             gain_sel;
    logic signed [OFFSET_W-1:0]    off_sel;
    logic [SPAN_W-1:0]             mul_a, mul_b;
    logic [PROD_W-1:0]             rounded;
    logic [GAINED_W-1:0]           gained;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       sat;

    msc_fold_div #(
        .FOLD_BITS (ADC_BITS),
        .DIV_W     (DIV_W),
        .QUO_W     (SPAN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign raw_sel  = chan_reg ? raw_volt_reg : raw_cur_reg;
    assign span_sel = chan_reg ? VOLTAGE_SPAN : CURRENT_SPAN;
    assign gain_sel = chan_reg ? cfg.voltage_gain : cfg.current_gain;
    assign off_sel  = $signed(chan_reg ? cfg.voltage_offset : cfg.current_offset);

    // shared multiplier: sample times span, then scaled value times gain
    assign mul_a = (state_reg == ST_SCALE) ? SPAN_W'(raw_sel) : div_quotient;
    assign mul_b = (state_reg == ST_SCALE) ? span_sel : SPAN_W'(gain_sel);

    assign div_start    = (state_reg == ST_START);
    assign div_dividend = DIV_W'(prod_reg) + DIV_W'(HALF_FS);

    assign rounded = prod_reg + PROD_W'(GAIN_ROUND);
    assign gained  = rounded[PROD_W-1:GAIN_FRAC];
    assign sum     = SUM_W'(off_sel) + $signed(SUM_W'(gained));

    always_comb
    begin
        if (sum > VAL_MAX)
        begin
            sat = VAL_MAX;
        end
        else if (sum < VAL_MIN)
        begin
            sat = VAL_MIN;
        end
        else
        begin
            sat = sum;
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign push_valid  = (state_reg == ST_PUSH);
    assign push_data   = {x_cur_reg, x_volt_reg, stamp_reg};

    always_comb
    begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        raw_cur_next  = raw_cur_reg;
        raw_volt_next = raw_volt_reg;
        stamp_next    = stamp_reg;
        prod_next     = prod_reg;
        x_cur_next    = x_cur_reg;
        x_volt_next   = x_volt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    raw_cur_next  = in_ch.raw_current;
                    raw_volt_next = in_ch.raw_voltage;
                    stamp_next    = in_ch.time_ms;
                    chan_next     = 1'b0;
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                prod_next  = {{SPAN_W{1'b0}}, mul_a} * {{SPAN_W{1'b0}}, mul_b};
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                prod_next  = {{SPAN_W{1'b0}}, mul_a} * {{SPAN_W{1'b0}}, mul_b};
                state_next = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                if (!chan_reg)
                begin
                    x_cur_next = sat[VALUE_WIDTH-1:0];
                    chan_next  = 1'b1;
                    state_next = ST_SCALE;
                end
                else
                begin
                    x_volt_next = sat[VALUE_WIDTH-1:0];
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_cur_reg  <= raw_cur_next;
        raw_volt_reg <= raw_volt_next;
        stamp_reg    <= stamp_next;
        prod_reg     <= prod_next;
        x_cur_reg    <= x_cur_next;
        x_volt_reg   <= x_volt_next;
    end

endmodule

[hdl/msc_back.sv]
// ----------------------------------------------------------------------------
// msc_back
// Exponential average with alpha 1/5, range check, sequence numbering and
// the output register.
// ----------------------------------------------------------------------------
module msc_back #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      pop_valid,
    output logic                                      pop_ready,
    input  logic [2*VALUE_WIDTH+msc_pkg::STAMP_W-1:0] pop_data,
    input  msc_pkg::back_cfg_t                        cfg,
    msc_out_if.source                                 out_ch
);
    import msc_pkg::*;

    // biased numerator x + 4*avg + 2 + 5*2^(w-1) is never negative
    localparam int NUM_W = VALUE_WIDTH + 3;
    localparam int DIV_W = VALUE_WIDTH + 8;
    localparam int CMP_W = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
    localparam logic [NUM_W-1:0] BIAS5 = NUM_W'(5) << (VALUE_WIDTH - 1);

    localparam logic [2:0] BK_IDLE = 3'd0;
    localparam logic [2:0] BK_FORM = 3'd1;
    localparam logic [2:0] BK_DIV  = 3'd2;
    localparam logic [2:0] BK_WAIT = 3'd3;
    localparam logic [2:0] BK_OUT  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic                          chan_reg, chan_next;
    logic                          loaded_reg, loaded_next;
    logic signed [VALUE_WIDTH-1:0] avg_cur_reg, avg_cur_next;
    logic signed [VALUE_WIDTH-1:0] avg_volt_reg, avg_volt_next;
    logic [SEQ_W-1:0]              seq_reg, seq_next;
    logic signed [VALUE_WIDTH-1:0] x_cur_reg, x_cur_next;
    logic signed [VALUE_WIDTH-1:0] x_volt_reg, x_volt_next;
    logic [STAMP_W-1:0]            stamp_reg, stamp_next;
    logic [NUM_W-1:0]              num_reg, num_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_cur_reg, out_cur_next;
    logic signed [VALUE_WIDTH-1:0] out_volt_reg, out_volt_next;
    logic                          out_bad_reg, out_bad_next;
    logic [SEQ_W-1:0]              out_seq_reg, out_seq_next;
    logic [STAMP_W-1:0]            out_stamp_reg, out_stamp_next;

    logic signed [VALUE_WIDTH-1:0] x_sel, avg_sel, avg_new;
    logic                          div_start;
    logic [DIV_W-1:0]              div_dividend;
    logic                          div_done;
    logic [VALUE_WIDTH-1:0]        div_quotient;
    logic                          cur_bad, volt_bad, bad, load_out;

    msc_fold_div #(
        .FOLD_BITS (AVG_FOLD_BITS),
        .DIV_W     (DIV_W),
        .QUO_W     (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign x_sel   = chan_reg ? x_volt_reg : x_cur_reg;
    assign avg_sel = chan_reg ? avg_volt_reg : avg_cur_reg;

    // n/5 = 51n/255
    assign div_start    = (state_reg == BK_DIV);
    assign div_dividend = DIV_W'(num_reg) * DIV_W'(AVG_MULT);

    // remove the bias again
    assign avg_new = $signed({~div_quotient[VALUE_WIDTH-1], div_quotient[VALUE_WIDTH-2:0]});

    assign cur_bad  = avg_cur_reg[VALUE_WIDTH-1] ||
                      (CMP_W'(avg_cur_reg[VALUE_WIDTH-2:0]) > CMP_W'(cfg.current_limit));
    assign volt_bad = avg_volt_reg[VALUE_WIDTH-1] ||
                      (CMP_W'(avg_volt_reg[VALUE_WIDTH-2:0]) > CMP_W'(cfg.voltage_limit));
    assign bad      = cur_bad || volt_bad;

    assign pop_ready = (state_reg == BK_IDLE);
    assign load_out  = (state_reg == BK_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        loaded_next   = loaded_reg;
        avg_cur_next  = avg_cur_reg;
        avg_volt_next = avg_volt_reg;
        seq_next      = seq_reg;
        x_cur_next    = x_cur_reg;
        x_volt_next   = x_volt_reg;
        stamp_next    = stamp_reg;
        num_next      = num_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    x_cur_next  = $signed(pop_data[2*VALUE_WIDTH+STAMP_W-1:VALUE_WIDTH+STAMP_W]);
                    x_volt_next = $signed(pop_data[VALUE_WIDTH+STAMP_W-1:STAMP_W]);
                    stamp_next  = pop_data[STAMP_W-1:0];
                    chan_next   = 1'b0;
                    if (!loaded_reg)
                    begin
                        // first pair loads the averages directly
                        avg_cur_next  = $signed(pop_data[2*VALUE_WIDTH+STAMP_W-1:VALUE_WIDTH+STAMP_W]);
                        avg_volt_next = $signed(pop_data[VALUE_WIDTH+STAMP_W-1:STAMP_W]);
                        loaded_next   = 1'b1;
                        state_next    = BK_OUT;
                    end
                    else
                    begin
                        state_next = BK_FORM;
                    end
                end
            end
            BK_FORM:
            begin
                num_next   = NUM_W'(x_sel) + (NUM_W'(avg_sel) << 2) + NUM_W'(2) + BIAS5;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (div_done)
                begin
                    if (!chan_reg)
                    begin
                        avg_cur_next = avg_new;
                        chan_next    = 1'b1;
                        state_next   = BK_FORM;
                    end
                    else
                    begin
                        avg_volt_next = avg_new;
                        state_next    = BK_OUT;
                    end
                end
            end
            BK_OUT:
            begin
                if (load_out)
                begin
                    if (!bad)
                    begin
                        seq_next = seq_reg + 1'b1;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cur_next   = out_cur_reg;
        out_volt_next  = out_volt_reg;
        out_bad_next   = out_bad_reg;
        out_seq_next   = out_seq_reg;
        out_stamp_next = out_stamp_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_cur_next   = avg_cur_reg;
            out_volt_next  = avg_volt_reg;
            out_bad_next   = bad;
            out_seq_next   = bad ? '0 : seq_reg;
            out_stamp_next = stamp_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            chan_reg      <= 1'b0;
            loaded_reg    <= 1'b0;
            avg_cur_reg   <= '0;
            avg_volt_reg  <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            loaded_reg    <= loaded_next;
            avg_cur_reg   <= avg_cur_next;
            avg_volt_reg  <= avg_volt_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_cur_reg     <= x_cur_next;
        x_volt_reg    <= x_volt_next;
        stamp_reg     <= stamp_next;
        num_reg       <= num_next;
        out_cur_reg   <= out_cur_next;
        out_volt_reg  <= out_volt_next;
        out_bad_reg   <= out_bad_next;
        out_seq_reg   <= out_seq_next;
        out_stamp_reg <= out_stamp_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.avg_current  = out_cur_reg;
    assign out_ch.avg_voltage  = out_volt_reg;
    assign out_ch.anomaly      = out_bad_reg;
    assign out_ch.sequence_res = out_seq_reg;
    assign out_ch.stamp_ms     = out_stamp_reg;

endmodule

[hdl/meter_sample_conditioner_top.sv]
// ----------------------------------------------------------------------------
// meter_sample_conditioner_top
// Conditions current and voltage sample pairs: scaling, gain, offset,
// exponential average and range check, with configuration registers.
//
// channel   role    word
// in_ch     sink    raw_current, raw_voltage, time_ms
// out_ch    source  avg_current, avg_voltage, anomaly, sequence_res, stamp_ms
// cfg_ch    sink    addr, wdata (register write, always ready)
//
// front and back sections run one word at a time, the back loading the first pair
// straight into its averages; how long a word takes depends on the folding divider loops
// a two-word queue between them lets the front take the next pair meanwhile
// the output register frees the back while a result waits to be taken
// reset clears averages, sequence count and registers to their defaults
// ----------------------------------------------------------------------------
module meter_sample_conditioner_top #(
    parameter int ADC_BITS    = 12,
    parameter int VALUE_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    msc_in_if.sink     in_ch,
    msc_out_if.source  out_ch,
    msc_cfg_if.sink    cfg_ch
);
    import msc_pkg::*;

    localparam int WORD_W = 2 * VALUE_WIDTH + STAMP_W;
    localparam int QUEUE_DEPTH = 2;

    logic [GAIN_W-1:0]   cur_gain_reg, cur_gain_next;
    logic [OFFSET_W-1:0] cur_off_reg, cur_off_next;
    logic [GAIN_W-1:0]   volt_gain_reg, volt_gain_next;
    logic [OFFSET_W-1:0] volt_off_reg, volt_off_next;
    logic [LIMIT_W-1:0]  cur_lim_reg, cur_lim_next;
    logic [LIMIT_W-1:0]  volt_lim_reg, volt_lim_next;

    front_cfg_t          front_cfg;
    back_cfg_t           back_cfg;

    logic                q_push_valid, q_push_ready;
    logic [WORD_W-1:0]   q_push_data;
    logic                q_pop_valid, q_pop_ready;
    logic [WORD_W-1:0]   q_pop_data;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cur_gain_next  = cur_gain_reg;
        cur_off_next   = cur_off_reg;
        volt_gain_next = volt_gain_reg;
        volt_off_next  = volt_off_reg;
        cur_lim_next   = cur_lim_reg;
        volt_lim_next  = volt_lim_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.addr)
                REG_CURRENT_GAIN:   cur_gain_next  = cfg_ch.wdata[GAIN_W-1:0];
                REG_CURRENT_OFFSET: cur_off_next   = cfg_ch.wdata[OFFSET_W-1:0];
                REG_VOLTAGE_GAIN:   volt_gain_next = cfg_ch.wdata[GAIN_W-1:0];
                REG_VOLTAGE_OFFSET: volt_off_next  = cfg_ch.wdata[OFFSET_W-1:0];
                REG_CURRENT_LIMIT:  cur_lim_next   = cfg_ch.wdata[LIMIT_W-1:0];
                REG_VOLTAGE_LIMIT:  volt_lim_next  = cfg_ch.wdata[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_gain_reg  <= GAIN_RESET;
            cur_off_reg   <= OFFSET_RESET;
            volt_gain_reg <= GAIN_RESET;
            volt_off_reg  <= OFFSET_RESET;
            cur_lim_reg   <= CURRENT_LIMIT_RESET;
            volt_lim_reg  <= VOLTAGE_LIMIT_RESET;
        end
        else
        begin
            cur_gain_reg  <= cur_gain_next;
            cur_off_reg   <= cur_off_next;
            volt_gain_reg <= volt_gain_next;
            volt_off_reg  <= volt_off_next;
            cur_lim_reg   <= cur_lim_next;
            volt_lim_reg  <= volt_lim_next;
        end
    end

    assign front_cfg.current_gain   = cur_gain_reg;
    assign front_cfg.current_offset = cur_off_reg;
    assign front_cfg.voltage_gain   = volt_gain_reg;
    assign front_cfg.voltage_offset = volt_off_reg;
    assign back_cfg.current_limit   = cur_lim_reg;
    assign back_cfg.voltage_limit   = volt_lim_reg;

    msc_front #(
        .ADC_BITS    (ADC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (front_cfg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    msc_queue #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    msc_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .cfg       (back_cfg),
        .out_ch    (out_ch)
    );

    // an anomaly never carries a sequence number
    a_anomaly_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.anomaly |-> out_ch.sequence_res == '0)
        else $error("anomaly word carries a sequence number");

    // an accepted reading has non-negative averages
    a_good_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.anomaly |->
        !out_ch.avg_current[VALUE_WIDTH-1] && !out_ch.avg_voltage[VALUE_WIDTH-1])
        else $error("accepted reading with negative average");

    // front takes one pair at a time
    a_front_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("front accepted two pairs in a row");

    // front never offers a word while it is taking a pair
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid |-> !in_ch.ready)
        else $error("front pushes while idle");

endmodule
